// ===== rtl/fprhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fprhc_pkg;

    localparam int NUM_HARTS = 8;
    localparam int NUM_REGS  = 32;
    localparam int DEPTH     = NUM_HARTS * NUM_REGS;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int CMD_W     = 2;
    localparam int HART_W    = 3;
    localparam int REG_W     = 5;
    localparam int CYCLE_W   = 64;
    localparam int INSN_W    = 32;
    localparam int KIND_W    = 3;
    localparam int VERDICT_W = 3;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INTMV = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INTMV = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WA    = 3'd4;

    localparam logic [VERDICT_W-1:0] VERDICT_OK       = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NO_NOP   = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_WA_A     = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_WA_B     = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_WA_C     = 3'd4;

    localparam logic [INSN_W-1:0]  FMV_MASK  = 32'hfff0_7fff;
    localparam logic [INSN_W-1:0]  FMV_ENC   = 32'he000_0053;
    localparam logic [CYCLE_W-1:0] LONG_GAP  = 64'd8;
    localparam logic [CYCLE_W-1:0] SHORT_GAP = 64'd1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CYCLE_W-1:0] cycle;
    } t_entry;

    typedef struct packed {
        logic               wen;
        logic [IDX_W-1:0]   idx;
        logic [KIND_W-1:0]  kind;
        logic [CYCLE_W-1:0] cycle;
    } t_update;

endpackage

`default_nettype wire

// ===== rtl/fprhc_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fprhc_state (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_rd_en,
    input  wire [fprhc_pkg::IDX_W-1:0]    i_rd_idx,
    input  wire fprhc_pkg::t_update       i_upd,
    output fprhc_pkg::t_entry             o_entry
);

    logic [fprhc_pkg::KIND_W-1:0]  mem_kind  [fprhc_pkg::DEPTH];
    logic [fprhc_pkg::CYCLE_W-1:0] mem_cycle [fprhc_pkg::DEPTH];
    logic [fprhc_pkg::DEPTH-1:0]   r_vld;

    logic                          r_rd_vld;
    logic [fprhc_pkg::KIND_W-1:0]  r_rd_kind;
    logic [fprhc_pkg::CYCLE_W-1:0] r_rd_cycle;
    logic                          r_hit;
    logic [fprhc_pkg::KIND_W-1:0]  r_fw_kind;
    logic [fprhc_pkg::CYCLE_W-1:0] r_fw_cycle;

    always_ff @(posedge i_clk) begin
        if (i_upd.wen) begin
            mem_kind[i_upd.idx]  <= i_upd.kind;
            mem_cycle[i_upd.idx] <= i_upd.cycle;
        end
        if (i_rd_en) begin
            r_rd_kind  <= mem_kind[i_rd_idx];
            r_rd_cycle <= mem_cycle[i_rd_idx];
            r_fw_kind  <= i_upd.kind;
            r_fw_cycle <= i_upd.cycle;
        end
    end

    // An entry that has never been written since reset reads as no pending access.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            if (i_upd.wen) begin
                r_vld[i_upd.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_idx];
                // The memory read sees the old contents when the previous
                // transaction writes the same entry at the same edge.
                r_hit    <= i_upd.wen && (i_upd.idx == i_rd_idx);
            end
        end
    end

    always_comb begin
        if (r_hit) begin
            o_entry.kind  = r_fw_kind;
            o_entry.cycle = r_fw_cycle;
        end else if (r_rd_vld) begin
            o_entry.kind  = r_rd_kind;
            o_entry.cycle = r_rd_cycle;
        end else begin
            o_entry.kind  = fprhc_pkg::KIND_NONE;
            o_entry.cycle = r_rd_cycle;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fprhc_decide.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fprhc_decide (
    input  wire [fprhc_pkg::CMD_W-1:0]     i_cmd,
    input  wire                            i_in_range,
    input  wire [fprhc_pkg::IDX_W-1:0]     i_idx,
    input  wire [fprhc_pkg::CYCLE_W-1:0]   i_now,
    input  wire [fprhc_pkg::INSN_W-1:0]    i_insn,
    input  wire fprhc_pkg::t_entry         i_entry,
    output logic [fprhc_pkg::VERDICT_W-1:0] o_verdict,
    output fprhc_pkg::t_update             o_upd
);

    logic [fprhc_pkg::CYCLE_W-1:0] elapsed;
    logic                          is_fmv;
    logic                          long_ok;
    logic                          short_ok;

    assign elapsed  = i_now - i_entry.cycle;
    assign is_fmv   = (i_insn & fprhc_pkg::FMV_MASK) == fprhc_pkg::FMV_ENC;
    assign long_ok  = elapsed >= fprhc_pkg::LONG_GAP;
    assign short_ok = elapsed > fprhc_pkg::SHORT_GAP;

    always_comb begin
        o_verdict  = fprhc_pkg::VERDICT_OK;
        o_upd.wen  = 1'b0;
        o_upd.idx  = i_idx;
        o_upd.kind = i_entry.kind;
        o_upd.cycle = i_entry.cycle;

        if (!i_in_range) begin
            o_verdict = fprhc_pkg::VERDICT_OK;
        end else if (i_cmd != fprhc_pkg::CMD_READ) begin
            o_upd.wen   = 1'b1;
            o_upd.cycle = i_now;
            unique case (i_cmd)
                fprhc_pkg::CMD_WRITE: o_upd.kind = fprhc_pkg::KIND_WRITE;
                fprhc_pkg::CMD_INTMV: o_upd.kind = fprhc_pkg::KIND_INTMV;
                default:              o_upd.kind = fprhc_pkg::KIND_LOAD;
            endcase
        end else begin
            priority if (i_entry.kind == fprhc_pkg::KIND_NONE) begin
                o_verdict = fprhc_pkg::VERDICT_OK;
            end else if ((i_entry.kind == fprhc_pkg::KIND_LOAD ||
                          i_entry.kind == fprhc_pkg::KIND_WRITE) && is_fmv) begin
                o_upd.wen   = 1'b1;
                o_upd.kind  = fprhc_pkg::KIND_WA;
                o_upd.cycle = i_now;
            end else if ((i_entry.kind == fprhc_pkg::KIND_WRITE ||
                          i_entry.kind == fprhc_pkg::KIND_INTMV) && long_ok) begin
                o_upd.wen  = 1'b1;
                o_upd.kind = fprhc_pkg::KIND_NONE;
            end else if (i_entry.kind == fprhc_pkg::KIND_WA) begin
                if (short_ok) begin
                    o_upd.wen  = 1'b1;
                    o_upd.kind = fprhc_pkg::KIND_NONE;
                end else begin
                    o_verdict = fprhc_pkg::VERDICT_NO_NOP;
                end
            end else if (i_entry.kind == fprhc_pkg::KIND_LOAD) begin
                o_verdict = fprhc_pkg::VERDICT_WA_A;
            end else if (i_entry.kind == fprhc_pkg::KIND_INTMV) begin
                o_verdict = fprhc_pkg::VERDICT_WA_B;
            end else if (i_entry.kind == fprhc_pkg::KIND_WRITE) begin
                o_verdict = fprhc_pkg::VERDICT_WA_C;
            end else begin
                o_verdict = fprhc_pkg::VERDICT_OK;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fp_register_hazard_checker_core.sv =====
// Floating-point register hazard checker.
// Input channel (i_in_valid / o_in_stall) takes one register access per
// transaction: command, hart, register, current cycle and the reading
// instruction. Output channel (o_out_valid / i_out_stall) returns one verdict
// per transaction, in order.
// An accepted transaction is captured in the input register and its table
// entry is read at the same edge; the verdict is loaded into the output
// register when the transaction advances and is visible from then on.
// Throughput: one transaction per cycle unless the receiver stalls. The table
// read, compare and write-back of one entry fit between the input and output
// registers, with a bypass for a transaction that reads the entry written by
// the one before. Reset clears both pipeline registers and marks every table
// entry as having no pending access; no clearing pass is needed, so
// transactions are taken as soon as reset is released.
// When the receiver stalls, the verdict holds in the output register, one
// further transaction can sit in the input register, and o_in_stall rises
// only when both are occupied.
`timescale 1ns / 1ps
`default_nettype none

module fp_register_hazard_checker_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire [fprhc_pkg::CMD_W-1:0]        i_cmd,
    input  wire [fprhc_pkg::HART_W-1:0]       i_hart,
    input  wire [fprhc_pkg::REG_W-1:0]        i_reg_index,
    input  wire [fprhc_pkg::CYCLE_W-1:0]      i_cycle_now,
    input  wire [fprhc_pkg::INSN_W-1:0]       i_insn_bits,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [fprhc_pkg::VERDICT_W-1:0]   o_verdict
);

    logic                             r_in_vld;
    logic [fprhc_pkg::CMD_W-1:0]      r_in_cmd;
    logic                             r_in_range;
    logic [fprhc_pkg::IDX_W-1:0]      r_in_idx;
    logic [fprhc_pkg::CYCLE_W-1:0]    r_in_now;
    logic [fprhc_pkg::INSN_W-1:0]     r_in_insn;
    logic                             r_out_vld;
    logic [fprhc_pkg::VERDICT_W-1:0]  r_out_verdict;

    logic                             accept;
    logic                             advance;
    logic                             in_range;
    logic [fprhc_pkg::IDX_W-1:0]      idx;
    logic [fprhc_pkg::VERDICT_W-1:0]  n_verdict;
    fprhc_pkg::t_entry                entry;
    fprhc_pkg::t_update               dec_upd;
    fprhc_pkg::t_update               upd;

    assign in_range = (32'(i_hart) < 32'(fprhc_pkg::NUM_HARTS)) &&
                      (32'(i_reg_index) < 32'(fprhc_pkg::NUM_REGS));
    assign idx      = fprhc_pkg::IDX_W'(i_hart) * fprhc_pkg::IDX_W'(fprhc_pkg::NUM_REGS)
                    + fprhc_pkg::IDX_W'(i_reg_index);

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        upd     = dec_upd;
        upd.wen = dec_upd.wen && advance;
    end

    fprhc_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_idx (idx),
        .i_upd    (upd),
        .o_entry  (entry)
    );

    fprhc_decide u_decide (
        .i_cmd      (r_in_cmd),
        .i_in_range (r_in_range),
        .i_idx      (r_in_idx),
        .i_now      (r_in_now),
        .i_insn     (r_in_insn),
        .i_entry    (entry),
        .o_verdict  (n_verdict),
        .o_upd      (dec_upd)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_cmd   <= i_cmd;
            r_in_range <= in_range;
            r_in_idx   <= idx;
            r_in_now   <= i_cycle_now;
            r_in_insn  <= i_insn_bits;
        end
        if (advance) begin
            r_out_verdict <= n_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_verdict   = r_out_verdict;

    // A write transaction always answers ok.
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_cmd != fprhc_pkg::CMD_READ) |=> (o_verdict == fprhc_pkg::VERDICT_OK))
        else $error("write transaction produced a non-ok verdict");

    // Verdicts stay within the defined codes.
    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict <= fprhc_pkg::VERDICT_WA_C))
        else $error("verdict code out of range");

    // Only a read can update an entry without having been a write command,
    // and an out-of-range transaction never touches the table.
    a_no_oob_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !r_in_range) |-> !upd.wen)
        else $error("out-of-range transaction wrote the table");

    // Reset leaves both pipeline registers empty.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_vld))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int MAX_SHOWN      = 10;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic [fprhc_pkg::CMD_W-1:0]     i_cmd       = '0;
    logic [fprhc_pkg::HART_W-1:0]    i_hart      = '0;
    logic [fprhc_pkg::REG_W-1:0]     i_reg_index = '0;
    logic [fprhc_pkg::CYCLE_W-1:0]   i_cycle_now = '0;
    logic [fprhc_pkg::INSN_W-1:0]    i_insn_bits = '0;
    logic                            i_out_stall = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic [fprhc_pkg::VERDICT_W-1:0] o_verdict;

    // Shadow of the hazard table, updated as each transaction is accepted.
    logic [fprhc_pkg::KIND_W-1:0]    kind_tbl [fprhc_pkg::DEPTH];
    logic [fprhc_pkg::CYCLE_W-1:0]   cycle_tbl [fprhc_pkg::DEPTH];
    // Entries the stimulus has written; reads are only aimed at these.
    bit                              touched [fprhc_pkg::DEPTH];

    logic [fprhc_pkg::VERDICT_W-1:0] verdict_q [$];
    int                              mismatches  = 0;
    int                              idle_cycles = 0;
    bit                              tx_gaps_on   = 1'b1;
    bit                              rx_stalls_on = 1'b1;

    fp_register_hazard_checker_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_hart      (i_hart),
        .i_reg_index (i_reg_index),
        .i_cycle_now (i_cycle_now),
        .i_insn_bits (i_insn_bits),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_verdict   (o_verdict)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [fprhc_pkg::IDX_W-1:0] entry_idx(
        input logic [fprhc_pkg::HART_W-1:0] hart,
        input logic [fprhc_pkg::REG_W-1:0]  rg
    );
        return fprhc_pkg::IDX_W'(int'(hart) * fprhc_pkg::NUM_REGS + int'(rg));
    endfunction

    function automatic logic [fprhc_pkg::VERDICT_W-1:0] predict_hazard(
        input logic [fprhc_pkg::CMD_W-1:0]   cmd,
        input logic [fprhc_pkg::HART_W-1:0]  hart,
        input logic [fprhc_pkg::REG_W-1:0]   rg,
        input logic [fprhc_pkg::CYCLE_W-1:0] now,
        input logic [fprhc_pkg::INSN_W-1:0]  insn
    );
        logic [fprhc_pkg::IDX_W-1:0]   idx;
        logic [fprhc_pkg::KIND_W-1:0]  kind;
        logic [fprhc_pkg::CYCLE_W-1:0] elapsed;
        logic                          fmv_x0;
        if (hart >= fprhc_pkg::NUM_HARTS || rg >= fprhc_pkg::NUM_REGS)
            return fprhc_pkg::VERDICT_OK;
        idx = entry_idx(hart, rg);
        if (cmd != fprhc_pkg::CMD_READ) begin
            cycle_tbl[idx] = now;
            case (cmd)
                fprhc_pkg::CMD_WRITE: kind_tbl[idx] = fprhc_pkg::KIND_WRITE;
                fprhc_pkg::CMD_INTMV: kind_tbl[idx] = fprhc_pkg::KIND_INTMV;
                default:              kind_tbl[idx] = fprhc_pkg::KIND_LOAD;
            endcase
            return fprhc_pkg::VERDICT_OK;
        end
        kind    = kind_tbl[idx];
        elapsed = now - cycle_tbl[idx];
        fmv_x0  = (insn & fprhc_pkg::FMV_MASK) == fprhc_pkg::FMV_ENC;
        if (kind == fprhc_pkg::KIND_NONE) return fprhc_pkg::VERDICT_OK;
        // The workaround is only recognised after a load or an arithmetic write.
        if ((kind == fprhc_pkg::KIND_LOAD || kind == fprhc_pkg::KIND_WRITE) && fmv_x0) begin
            cycle_tbl[idx] = now;
            kind_tbl[idx]  = fprhc_pkg::KIND_WA;
            return fprhc_pkg::VERDICT_OK;
        end
        if ((kind == fprhc_pkg::KIND_WRITE || kind == fprhc_pkg::KIND_INTMV) &&
            elapsed >= fprhc_pkg::LONG_GAP) begin
            kind_tbl[idx] = fprhc_pkg::KIND_NONE;
            return fprhc_pkg::VERDICT_OK;
        end
        if (kind == fprhc_pkg::KIND_WA) begin
            if (elapsed > fprhc_pkg::SHORT_GAP) begin
                kind_tbl[idx] = fprhc_pkg::KIND_NONE;
                return fprhc_pkg::VERDICT_OK;
            end
            return fprhc_pkg::VERDICT_NO_NOP;
        end
        case (kind)
            fprhc_pkg::KIND_LOAD:  return fprhc_pkg::VERDICT_WA_A;
            fprhc_pkg::KIND_INTMV: return fprhc_pkg::VERDICT_WA_B;
            default:               return fprhc_pkg::VERDICT_WA_C;
        endcase
    endfunction

    // Results are checked before the new transaction is predicted, so a
    // verdict can never be matched against the transaction of the same edge.
    always @(posedge i_clk) begin
        logic [fprhc_pkg::VERDICT_W-1:0] want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    if (mismatches < MAX_SHOWN)
                        $display("unexpected verdict %0d with nothing outstanding",
                                 o_verdict);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_verdict !== want) begin
                        if (mismatches < MAX_SHOWN)
                            $display("verdict mismatch: expected %0d, got %0d",
                                     want, o_verdict);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                verdict_q.push_back(predict_hazard(i_cmd, i_hart, i_reg_index,
                                                   i_cycle_now, i_insn_bits));
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("fp_register_hazard_checker_core test failed");
            $finish;
        end
    end

    // Receiver back-pressure in bursts, with long stretches of none.
    initial begin
        @(negedge i_clk);
        forever begin
            if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(negedge i_clk);
            end
        end
    end

    task automatic send_access(
        input logic [fprhc_pkg::CMD_W-1:0]   cmd,
        input logic [fprhc_pkg::HART_W-1:0]  hart,
        input logic [fprhc_pkg::REG_W-1:0]   rg,
        input logic [fprhc_pkg::CYCLE_W-1:0] now,
        input logic [fprhc_pkg::INSN_W-1:0]  insn
    );
        int gap;
        if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
            gap = int'($urandom_range(1, 17));
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_hart      <= hart;
        i_reg_index <= rg;
        i_cycle_now <= now;
        i_insn_bits <= insn;
        if (cmd != fprhc_pkg::CMD_READ) touched[entry_idx(hart, rg)] = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [fprhc_pkg::INSN_W-1:0] fmv_insn();
        // Only the source register field is free in the fmv.x.w x0 pattern.
        return ($urandom & ~fprhc_pkg::FMV_MASK) | fprhc_pkg::FMV_ENC;
    endfunction

    function automatic logic [fprhc_pkg::CYCLE_W-1:0] random_cycle();
        logic [fprhc_pkg::CYCLE_W-1:0] c;
        if ($urandom_range(0, 7) == 0) begin
            c = '1;
            c = c - fprhc_pkg::CYCLE_W'($urandom_range(0, 20));
        end else begin
            c = {$urandom, $urandom};
        end
        return c;
    endfunction

    function automatic logic [fprhc_pkg::CYCLE_W-1:0] read_delay();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return 64'd1;
            2:       return 64'd2;
            3:       return 64'd7;
            4:       return 64'd8;
            5:       return 64'd9;
            default: return fprhc_pkg::CYCLE_W'($urandom_range(0, 40));
        endcase
    endfunction

    // Mostly write-then-read sequences on one entry, with some random noise.
    task automatic run_sequences(input int n_items, input bit pause_midway);
        int                            sent;
        int                            n_reads;
        bit                            paused;
        logic [fprhc_pkg::CMD_W-1:0]   cmd;
        logic [fprhc_pkg::HART_W-1:0]  hart;
        logic [fprhc_pkg::REG_W-1:0]   rg;
        logic [fprhc_pkg::CYCLE_W-1:0] now;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            hart = fprhc_pkg::HART_W'($urandom_range(0, fprhc_pkg::NUM_HARTS - 1));
            rg   = fprhc_pkg::REG_W'($urandom_range(0, fprhc_pkg::NUM_REGS - 1));
            if ($urandom_range(0, 4) == 0) begin
                cmd = fprhc_pkg::CMD_W'($urandom_range(0, 3));
                if (cmd == fprhc_pkg::CMD_READ && !touched[entry_idx(hart, rg)])
                    cmd = fprhc_pkg::CMD_W'($urandom_range(1, 3));
                send_access(cmd, hart, rg, {$urandom, $urandom}, $urandom);
                sent++;
            end else begin
                now = random_cycle();
                send_access(fprhc_pkg::CMD_W'($urandom_range(1, 3)), hart, rg, now,
                            $urandom);
                sent++;
                n_reads = int'($urandom_range(1, 4));
                repeat (n_reads) begin
                    now = now + read_delay();
                    send_access(fprhc_pkg::CMD_READ, hart, rg, now,
                                ($urandom_range(0, 2) == 0) ? fmv_insn() : $urandom);
                    sent++;
                end
            end
            if (pause_midway && !paused && sent >= n_items / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_write_hazard();
        send_access(fprhc_pkg::CMD_WRITE, 3'd0, 5'd0, 64'd100, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd0, 5'd0, 64'd107, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd0, 5'd0, 64'd108, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd0, 5'd0, 64'd100, fmv_insn());
    endtask

    task automatic test_intmv_hazard();
        // An fmv.x.w x0 after an integer move is an ordinary read.
        send_access(fprhc_pkg::CMD_INTMV, 3'd7, 5'd31, 64'd0, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd7, 5'd31, 64'd3, fmv_insn());
        send_access(fprhc_pkg::CMD_READ, 3'd7, 5'd31, 64'd8, 32'hffff_ffff);
    endtask

    task automatic test_load_workaround();
        send_access(fprhc_pkg::CMD_LOAD, 3'd3, 5'd17, 64'd50, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd3, 5'd17, 64'd5000, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd3, 5'd17, 64'd5001, fprhc_pkg::FMV_ENC);
        send_access(fprhc_pkg::CMD_READ, 3'd3, 5'd17, 64'd5001, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd3, 5'd17, 64'd5002, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd3, 5'd17, 64'd5003, 32'd0);
        send_access(fprhc_pkg::CMD_WRITE, 3'd5, 5'd9, 64'd10, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd5, 5'd9, 64'd11,
                    fprhc_pkg::FMV_ENC | 32'h000f_8000);
        send_access(fprhc_pkg::CMD_READ, 3'd5, 5'd9, 64'd12, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd5, 5'd9, 64'd13, 32'd0);
    endtask

    task automatic test_cycle_wrap();
        send_access(fprhc_pkg::CMD_WRITE, 3'd1, 5'd2, 64'hffff_ffff_ffff_fffd, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd1, 5'd2, 64'd4, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd1, 5'd2, 64'd5, 32'd0);
        send_access(fprhc_pkg::CMD_LOAD, 3'd2, 5'd1, 64'hffff_ffff_ffff_ffff, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd2, 5'd1, 64'hffff_ffff_ffff_ffff,
                    fprhc_pkg::FMV_ENC);
        send_access(fprhc_pkg::CMD_READ, 3'd2, 5'd1, 64'd0, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd2, 5'd1, 64'd1, 32'd0);
        send_access(fprhc_pkg::CMD_WRITE, 3'd6, 5'd30, 64'd0, 32'd0);
        send_access(fprhc_pkg::CMD_READ, 3'd6, 5'd30, 64'd1, 32'hffff_ffff);
    endtask

    task automatic test_random_mix();
        run_sequences(600, 1'b1);
    endtask

    task automatic test_full_rate();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        run_sequences(100, 1'b0);
    endtask

    initial begin
        foreach (kind_tbl[i]) begin
            kind_tbl[i]  = fprhc_pkg::KIND_NONE;
            cycle_tbl[i] = '0;
            touched[i]   = 1'b0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_write_hazard();
        test_intmv_hazard();
        test_load_workaround();
        test_cycle_wrap();
        wait_drained();
        test_random_mix();
        test_full_rate();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("fp_register_hazard_checker_core test passed");
        end else begin
            $display("fp_register_hazard_checker_core test failed");
        end
        $finish;
    end

endmodule

// ===== fp_register_hazard_checker_core.f =====
rtl/fprhc_pkg.sv
rtl/fprhc_state.sv
rtl/fprhc_decide.sv
rtl/fp_register_hazard_checker_core.sv
tb/sv/tb.sv
